// ===== rtl/citp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// citp_pkg
// Types and constants shared by the checked integer text parser modules.
// ----------------------------------------------------------------------------
package citp_pkg;

    localparam int OUT_W   = 64;
    localparam int CHAR_W  = 8;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_TOO_BIG   = 2'd2;
    localparam logic [1:0] ST_TOO_SMALL = 2'd3;

    // register indexes
    localparam logic [0:0] REG_RADIX  = 1'b0;
    localparam logic [0:0] REG_SIGNED = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] BASE_TEN    = 5'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 5'd16;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_F   = 8'd70;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LOW_F  = 8'd102;
    localparam logic [CHAR_W-1:0] HEX_SHIFT = 8'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              no_char;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] result_value;
        logic [1:0]       status;
    } t_out_item;

    typedef enum logic [2:0] {
        K_NONE,
        K_BLANK,
        K_PLUS,
        K_MINUS,
        K_DIGIT,
        K_OTHER
    } t_kind;

    // classified request handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
        logic [RADIX_W-1:0] base;
        logic               smode;
        logic               last;
    } t_op;

endpackage
`default_nettype wire

// ===== rtl/citp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// citp_front
// Config registers, character classification and the request queue.
// ----------------------------------------------------------------------------
module citp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [4:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    input  citp_pkg::t_in_item i_in,
    output logic              o_in_stall,
    output logic              o_q_valid,
    output citp_pkg::t_op     o_q_op,
    input  logic              i_q_pop
);
    import citp_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic               r_smode;

    t_op                r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;

    logic [RADIX_W-1:0] base;
    logic [CHAR_W-1:0]  c;
    logic [CHAR_W-1:0]  c_off;
    logic [CHAR_W-1:0]  c_hex;
    logic               is_dig;
    logic [DIGIT_W-1:0] dig;
    t_op                op;
    logic               full;
    logic               push;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_smode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RADIX:  r_radix <= i_cfg_wdata;
                REG_SIGNED: r_smode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        c      = i_in.char_code;
        base   = r_smode ? BASE_TEN : r_radix;
        c_off  = c - CH_ZERO;
        c_hex  = '0;
        is_dig = 1'b0;
        dig    = '0;
        if (base <= BASE_TEN) begin
            if (c >= CH_ZERO && c_off < {3'b000, base}) begin
                is_dig = 1'b1;
                dig    = c_off[DIGIT_W-1:0];
            end
        end else if (base == BASE_HEX) begin
            if (c inside {[CH_ZERO:CH_NINE]}) begin
                is_dig = 1'b1;
                dig    = c_off[DIGIT_W-1:0];
            end else if (c inside {[CH_LOW_A:CH_LOW_F]}) begin
                is_dig = 1'b1;
                c_hex  = c - CH_LOW_A + HEX_SHIFT;
                dig    = c_hex[DIGIT_W-1:0];
            end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
                is_dig = 1'b1;
                c_hex  = c - CH_UP_A + HEX_SHIFT;
                dig    = c_hex[DIGIT_W-1:0];
            end
        end

        op.digit = dig;
        op.base  = base;
        op.smode = r_smode;
        op.last  = i_in.last;
        if (i_in.no_char) begin
            op.kind = K_NONE;
        end else if (c inside {[CH_TAB:CH_CR], CH_SPACE}) begin
            op.kind = K_BLANK;
        end else if (r_smode && c == CH_PLUS) begin
            op.kind = K_PLUS;
        end else if (r_smode && c == CH_MINUS) begin
            op.kind = K_MINUS;
        end else if (is_dig) begin
            op.kind = K_DIGIT;
        end else begin
            op.kind = K_OTHER;
        end
    end

    assign full       = (r_count == CNT_W'(Q_DEPTH));
    assign o_in_stall = full;
    assign o_q_valid  = (r_count != '0);
    assign o_q_op     = r_mem[r_rptr];
    assign push       = i_in_valid && !full;
    assign pop        = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/citp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// citp_back
// Digit accumulation with overflow check, final saturation and result register.
// ----------------------------------------------------------------------------
module citp_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  citp_pkg::t_op      i_q_op,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output citp_pkg::t_out_item o_out,
    input  logic               i_out_stall
);
    import citp_pkg::*;

    localparam int PW = VALUE_BITS + RADIX_W;

    localparam logic [1:0] SS_OK      = 2'd0;
    localparam logic [1:0] SS_INVALID = 2'd1;
    localparam logic [1:0] SS_OVF     = 2'd2;

    localparam logic [VALUE_BITS-1:0] UMAX = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] SMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] SMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_EXEC = 3'b010,
        B_FIN  = 3'b100
    } t_bstate;

    typedef enum logic [3:0] {
        P_LEAD   = 4'b0001,
        P_SIGN   = 4'b0010,
        P_DIGITS = 4'b0100,
        P_DONE   = 4'b1000
    } t_phase;

    t_bstate               r_state,  n_state;
    t_phase                r_phase,  n_phase;
    logic [VALUE_BITS-1:0] r_acc,    n_acc;
    logic                  r_neg,    n_neg;
    logic [1:0]            r_sticky, n_sticky;
    t_op                   r_cur,    n_cur;
    logic [PW-1:0]         r_prod,   n_prod;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out,    n_out;

    logic [VALUE_BITS:0]   sum;
    logic [VALUE_BITS-1:0] fin_val;
    logic [1:0]            fin_st;
    logic                  out_free;

    assign o_q_pop     = (r_state == B_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign sum = {1'b0, r_prod[VALUE_BITS-1:0]} + (VALUE_BITS + 1)'(r_cur.digit);

    always_comb begin
        fin_val = '0;
        fin_st  = ST_OK;
        if (r_sticky == SS_INVALID || r_phase == P_LEAD || r_phase == P_SIGN) begin
            fin_st = ST_INVALID;
        end else if (!r_cur.smode) begin
            if (r_sticky == SS_OVF) begin
                fin_val = UMAX;
                fin_st  = ST_TOO_BIG;
            end else begin
                fin_val = r_acc;
            end
        end else if (r_neg) begin
            if (r_sticky == SS_OVF || (r_acc[VALUE_BITS-1] && r_acc[VALUE_BITS-2:0] != '0)) begin
                fin_val = SMIN;
                fin_st  = ST_TOO_SMALL;
            end else begin
                fin_val = '0 - r_acc;
            end
        end else begin
            if (r_sticky == SS_OVF || r_acc[VALUE_BITS-1]) begin
                fin_val = SMAX;
                fin_st  = ST_TOO_BIG;
            end else begin
                fin_val = r_acc;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_sticky    = r_sticky;
        n_cur       = r_cur;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    n_cur   = i_q_op;
                    n_prod  = PW'(r_acc) * PW'(i_q_op.base);
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                if (r_phase == P_DONE || r_cur.kind == K_NONE) begin
                    n_phase = r_phase;
                end else if (r_phase == P_LEAD && r_cur.kind == K_BLANK) begin
                    n_phase = r_phase;
                end else if (r_phase == P_LEAD
                             && (r_cur.kind == K_PLUS || r_cur.kind == K_MINUS)) begin
                    n_neg   = (r_cur.kind == K_MINUS);
                    n_phase = P_SIGN;
                end else if (r_phase == P_SIGN && r_cur.kind == K_BLANK) begin
                    n_phase = r_phase;
                end else if (r_cur.kind != K_DIGIT) begin
                    if (r_phase != P_DIGITS) begin
                        n_sticky = SS_INVALID;
                    end
                    n_phase = P_DONE;
                end else if (r_prod[PW-1:VALUE_BITS] != '0 || sum[VALUE_BITS]) begin
                    n_sticky = SS_OVF;
                    n_phase  = P_DONE;
                end else begin
                    n_acc   = sum[VALUE_BITS-1:0];
                    n_phase = P_DIGITS;
                end
                n_state = r_cur.last ? B_FIN : B_IDLE;
            end
            B_FIN: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = OUT_W'(fin_val);
                    n_out.status       = fin_st;
                    n_phase            = P_LEAD;
                    n_acc              = '0;
                    n_neg              = 1'b0;
                    n_sticky           = SS_OK;
                    n_state            = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_phase     <= P_LEAD;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_sticky    <= SS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_sticky    <= n_sticky;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

endmodule
`default_nettype wire

// ===== rtl/checked_integer_text_parser.sv =====
`default_nettype none
// The back end multiplies by the base, then adds and checks each character;
// the last one of a string also passes final saturation to the result
// register. It takes no new request until it is through with the last one.
// The 2-entry request queue absorbs input while the back end works.
// Reset (synchronous, active low) sets radix 10, signed mode, empty queue.
// ----------------------------------------------------------------------------
// checked_integer_text_parser
// Parses a number string, one character per request, into a saturated value.
// ----------------------------------------------------------------------------
module checked_integer_text_parser #(
    parameter int VALUE_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [4:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    input  citp_pkg::t_in_item  i_in,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output citp_pkg::t_out_item o_out,
    input  logic                i_out_stall
);
    import citp_pkg::*;

    logic q_valid;
    t_op  q_op;
    logic q_pop;

    citp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_q_valid   (q_valid),
        .o_q_op      (q_op),
        .i_q_pop     (q_pop)
    );

    citp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checked integer text parser. Strings of
// characters are sent as requests: well-formed numbers (blanks, sign, digits
// in the current base, near-limit values, terminators) and random byte noise.
// A scoreboard scans every accepted request and predicts value and status for
// each string end. Results are compared field by field in arrival order.
// Both handshakes idle at random, the receiver holds off once for a long
// stretch, and the registers cycle through several settings between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import citp_pkg::*;

    localparam logic [OUT_W-1:0] VAL_MAX = {OUT_W{1'b1}};
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 80;
    localparam int NUM_PHASES   = 10;

    typedef enum logic [1:0] {
        SCAN_LEAD,
        SCAN_AFTER_SIGN,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_e;

    typedef enum logic [1:0] {
        FLAG_OK,
        FLAG_INVALID,
        FLAG_OVERFLOW
    } scan_flag_e;

    class parse_scoreboard;
        t_out_item          expected_q[$];
        logic [RADIX_W-1:0] radix;
        logic               signed_mode;
        scan_phase_e        phase;
        scan_flag_e         flag;
        logic [OUT_W-1:0]   acc;
        logic               negative;
        int                 mismatches;
        int                 checked;
        int                 status_seen[4];

        function new();
            radix       = RADIX_RESET;
            signed_mode = 1'b1;
            mismatches  = 0;
            checked     = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            phase    = SCAN_LEAD;
            flag     = FLAG_OK;
            acc      = '0;
            negative = 1'b0;
        endfunction

        function void set_register(logic [0:0] idx, logic [RADIX_W-1:0] data);
            if (idx == REG_RADIX) begin
                radix = data;
            end else begin
                signed_mode = data[0];
            end
        endfunction

        // -1 when the byte is no digit of the base
        function int digit_value(logic [CHAR_W-1:0] c, logic [RADIX_W-1:0] base);
            if (base <= BASE_TEN) begin
                if (c >= CH_ZERO && c < CH_ZERO + base) return int'(c - CH_ZERO);
                return -1;
            end
            if (base == BASE_HEX) begin
                if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
                if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A + HEX_SHIFT);
                if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A + HEX_SHIFT);
            end
            return -1;
        endfunction

        function void absorb_char(logic [CHAR_W-1:0] c);
            logic [RADIX_W-1:0] base;
            logic               blank;
            int                 d;
            base  = signed_mode ? BASE_TEN : radix;
            blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            if (phase == SCAN_DONE) return;
            if (phase == SCAN_LEAD && blank) return;
            if (phase == SCAN_LEAD && signed_mode && (c == CH_PLUS || c == CH_MINUS)) begin
                negative = (c == CH_MINUS);
                phase    = SCAN_AFTER_SIGN;
                return;
            end
            if (phase == SCAN_AFTER_SIGN && blank) return;
            d = digit_value(c, base);
            if (d < 0) begin
                if (phase != SCAN_DIGITS) flag = FLAG_INVALID;
                phase = SCAN_DONE;
                return;
            end
            phase = SCAN_DIGITS;
            if (acc > VAL_MAX / OUT_W'(base)) begin
                flag  = FLAG_OVERFLOW;
                phase = SCAN_DONE;
                return;
            end
            acc = acc * OUT_W'(base);
            if (VAL_MAX - acc < OUT_W'(d)) begin
                flag  = FLAG_OVERFLOW;
                phase = SCAN_DONE;
                return;
            end
            acc = acc + OUT_W'(d);
        endfunction

        function t_out_item close_string();
            t_out_item        r;
            logic [OUT_W-1:0] smax;
            smax           = VAL_MAX >> 1;
            r.result_value = '0;
            r.status       = ST_OK;
            if (flag == FLAG_INVALID || phase == SCAN_LEAD || phase == SCAN_AFTER_SIGN) begin
                r.status = ST_INVALID;
            end else if (!signed_mode) begin
                if (flag == FLAG_OVERFLOW) begin
                    r.result_value = VAL_MAX;
                    r.status       = ST_TOO_BIG;
                end else begin
                    r.result_value = acc;
                end
            end else if (negative) begin
                if (flag == FLAG_OVERFLOW || acc > smax + 1) begin
                    r.result_value = smax + 1;
                    r.status       = ST_TOO_SMALL;
                end else begin
                    r.result_value = -acc;
                end
            end else begin
                if (flag == FLAG_OVERFLOW || acc > smax) begin
                    r.result_value = smax;
                    r.status       = ST_TOO_BIG;
                end else begin
                    r.result_value = acc;
                end
            end
            return r;
        endfunction

        function void note_request(t_in_item it);
            if (!it.no_char) absorb_char(it.char_code);
            if (it.last) begin
                expected_q.push_back(close_string());
                clear_scan();
            end
        endfunction

        function void log_mismatch(string msg);
            mismatches++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                log_mismatch($sformatf("unexpected result: value %h status %0d",
                                       got.result_value, got.status));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.result_value !== want.result_value)
                log_mismatch($sformatf("value: expected %h actual %h",
                                       want.result_value, got.result_value));
            if (got.status !== want.status)
                log_mismatch($sformatf("status: expected %0d actual %0d",
                                       want.status, got.status));
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [0:0]         cfg_index = '0;
    logic [RADIX_W-1:0] cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    t_in_item           in_item   = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_item;
    logic               out_stall = 1'b0;

    parse_scoreboard sb;
    t_in_item        str_q[$];
    int              burst_left    = 0;
    int              items_sent    = 0;
    int              counted_items = 0;
    int              results_seen  = 0;
    int              settings_used = 0;
    int              cycle_count   = 0;

    logic [RADIX_W-1:0] phase_radix[8] = '{BASE_TEN, BASE_HEX, 5'd2, BASE_TEN,
                                           5'd8, BASE_HEX, 5'd31, 5'd1};
    logic [7:0]         phase_signed   = 8'b0010_0001;

    checked_integer_text_parser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in        (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_item),
        .i_out_stall (out_stall)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_item);
            results_seen++;
        end
    end

    // receiver: stall mode changes now and then at random, one long hold-off
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        bit held;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && results_seen >= 30) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (mode_left % 8 < 3);
                endcase
            end
        end
    end

    function automatic void add_char(logic [CHAR_W-1:0] c, logic no_char, logic last);
        t_in_item it;
        it.char_code = c;
        it.no_char   = no_char;
        it.last      = last;
        str_q.push_back(it);
    endfunction

    // now and then an ignored empty request slips in before a character
    function automatic void push_text(logic [CHAR_W-1:0] c);
        if ($urandom_range(0, 15) == 0) add_char(CHAR_W'($urandom), 1'b1, 1'b0);
        add_char(c, 1'b0, 1'b0);
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + CHAR_W'(r);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(int v, bit upper);
        if (v < int'(HEX_SHIFT)) return CH_ZERO + CHAR_W'(v);
        return (upper ? CH_UP_A : CH_LOW_A) + CHAR_W'(v) - HEX_SHIFT;
    endfunction

    function automatic void build_number();
        logic [RADIX_W-1:0] base;
        logic [OUT_W-1:0]   val;
        logic [CHAR_W-1:0]  digs[$];
        logic [CHAR_W-1:0]  c;
        bit                 has_digits;
        int                 dspan;
        int                 n;
        base       = sb.signed_mode ? BASE_TEN : sb.radix;
        has_digits = (base >= 2 && base <= BASE_TEN) || base == BASE_HEX;
        dspan      = (base == 1) ? 2 : (has_digits ? int'(base) : 16);
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) push_text(blank_char());
        if (sb.signed_mode && $urandom_range(0, 1)) begin
            push_text($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) push_text(blank_char());
        end
        if (has_digits && $urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 6))
                0: val = (VAL_MAX >> 1) - 1;
                1: val = VAL_MAX >> 1;
                2: val = (VAL_MAX >> 1) + 1;
                3: val = (VAL_MAX >> 1) + 2;
                4: val = VAL_MAX - 1;
                5: val = VAL_MAX;
                default: val = {$urandom, $urandom};
            endcase
            do begin
                digs.push_front(digit_char(int'(val % OUT_W'(base)), $urandom_range(0, 1)));
                val = val / OUT_W'(base);
            end while (val != 0);
            foreach (digs[i]) push_text(digs[i]);
            if ($urandom_range(0, 3) == 0)
                push_text(digit_char($urandom_range(0, int'(base) - 1), 1'b0));
        end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
            repeat (n) push_text(digit_char($urandom_range(0, dspan - 1), $urandom_range(0, 1)));
        end
        if ($urandom_range(0, 1)) begin
            do c = CHAR_W'($urandom); while (sb.digit_value(c, base) >= 0);
            push_text(c);
            n = $urandom_range(0, 3);
            repeat (n) push_text(CHAR_W'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            add_char(CHAR_W'($urandom), 1'b1, 1'b1);
        end else begin
            str_q[$].last = 1'b1;
        end
    endfunction

    function automatic void build_noise();
        int n;
        if ($urandom_range(0, 7) == 0) begin
            add_char(CHAR_W'($urandom), 1'b1, 1'b1);
            return;
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 1)) begin
                push_text(CHAR_W'($urandom));
            end else begin
                case ($urandom_range(0, 5))
                    0: push_text(blank_char());
                    1: push_text(CH_PLUS);
                    2: push_text(CH_MINUS);
                    3: push_text(digit_char($urandom_range(0, 15), $urandom_range(0, 1)));
                    4: push_text(CH_UP_F + 8'd1);
                    default: push_text(CHAR_W'($urandom_range(128, 255)));
                endcase
            end
        end
        str_q[$].last = 1'b1;
    endfunction

    // one request, with a random gap at the start of each burst
    task automatic offer(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                in_item  <= t_in_item'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(it);
        items_sent++;
        if (!(it.no_char && !it.last)) counted_items++;
    endtask

    task automatic send_string();
        foreach (str_q[i]) offer(str_q[i]);
        str_q.delete();
    endtask

    task automatic idle_until_drained();
        @(negedge clk);
        in_valid  <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [RADIX_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= RADIX_W'($urandom);
    endtask

    initial begin : stimulus
        int                 start;
        logic [RADIX_W-1:0] rdx;
        logic               sgn;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: signed, base ten
        settings_used = 1;
        add_char(8'hFF, 1'b1, 1'b1);
        add_char(CH_SPACE, 1'b0, 1'b0);
        add_char(CH_CR, 1'b0, 1'b1);
        add_char(CH_PLUS, 1'b0, 1'b0);
        add_char(CH_MINUS, 1'b0, 1'b0);
        add_char(CH_ZERO + 8'd5, 1'b0, 1'b1);
        add_char(CH_MINUS, 1'b0, 1'b0);
        add_char(CH_TAB, 1'b0, 1'b0);
        add_char(8'h00, 1'b1, 1'b1);
        add_char(CH_MINUS, 1'b0, 1'b0);
        add_char(CH_ZERO, 1'b0, 1'b1);
        add_char(8'h00, 1'b0, 1'b1);
        add_char(CH_ZERO + 8'd7, 1'b0, 1'b0);
        add_char(8'hAA, 1'b1, 1'b0);
        add_char(CH_ZERO + 8'd3, 1'b0, 1'b0);
        add_char(8'hFF, 1'b0, 1'b1);
        add_char(8'hB5, 1'b0, 1'b0);
        add_char(CH_ZERO + 8'd1, 1'b0, 1'b1);
        send_string();

        // unsigned hex, sign rejected, base switched mid-string
        idle_until_drained();
        write_reg(REG_SIGNED, {4'b1110, 1'b0});
        write_reg(REG_RADIX, BASE_HEX);
        settings_used++;
        add_char(CH_LOW_F, 1'b0, 1'b0);
        add_char(CH_UP_F, 1'b0, 1'b1);
        add_char(CH_PLUS, 1'b0, 1'b0);
        add_char(CH_ZERO + 8'd5, 1'b0, 1'b1);
        add_char(CH_ZERO + 8'd1, 1'b0, 1'b0);
        send_string();
        idle_until_drained();
        write_reg(REG_RADIX, 5'd1);
        settings_used++;
        add_char(CH_ZERO, 1'b0, 1'b0);
        add_char(CH_ZERO + 8'd1, 1'b0, 1'b1);
        send_string();
        idle_until_drained();
        write_reg(REG_RADIX, 5'd0);
        settings_used++;
        add_char(CH_ZERO + 8'd5, 1'b0, 1'b1);
        send_string();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 8) begin
                rdx = phase_radix[p];
                sgn = phase_signed[p];
            end else begin
                rdx = RADIX_W'($urandom);
                sgn = $urandom_range(0, 1);
            end
            idle_until_drained();
            write_reg(REG_RADIX, rdx);
            write_reg(REG_SIGNED, {4'($urandom_range(0, 15)), sgn});
            settings_used++;
            start = counted_items;
            while (counted_items - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    build_number();
                end else begin
                    build_noise();
                end
                send_string();
            end
        end

        idle_until_drained();
        $display("covered %0d requests, %0d results, %0d register settings",
                 items_sent, sb.checked, settings_used);
        $display("statuses: ok %0d, invalid %0d, too big %0d, too small %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_INVALID],
                 sb.status_seen[ST_TOO_BIG], sb.status_seen[ST_TOO_SMALL]);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/citp_pkg.sv
rtl/citp_front.sv
rtl/citp_back.sv
rtl/checked_integer_text_parser.sv
verif/tb_top.sv
